/* design/assert_macros.svh */
// Assertion helpers shared by the glyph rasterizer modules.
// Each expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset
`define TCGR_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Check a consequence in the same cycle
`define TCGR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Check a consequence in the following cycle
`define TCGR_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/tcgr_pkg.sv */
package tcgr_pkg;

	// Cell geometry
	localparam int CELL_WIDTH  = 8;
	localparam int CELL_HEIGHT = 16;
	localparam int LANE_W      = (CELL_WIDTH > 1) ? $clog2(CELL_WIDTH) : 1;

	// Character and attribute constants
	localparam logic [7:0] SPACE_CODE  = 8'h20;
	localparam logic [7:0] LEFT_BIT    = 8'h80;
	localparam logic [3:0] NIBBLE_MASK = 4'hF;

	// Configuration register indexes
	typedef enum logic [2:0] {
		CFG_CURSOR_ENABLE = 3'd0,
		CFG_CURSOR_ROW    = 3'd1,
		CFG_CURSOR_COLUMN = 3'd2,
		CFG_DEFAULT_ATTR  = 3'd3,
		CFG_TRANSP_BG     = 3'd4
	} cfg_idx_t;

	// Configuration register set
	typedef struct packed {
		logic       cursor_enable;
		logic [4:0] cursor_row;
		logic [6:0] cursor_column;
		logic [7:0] blank_attr;
		logic [3:0] transparent_background;
	} cfg_t;

	// Decoded glyph line, shared by all lanes
	typedef struct packed {
		logic [9:0] base_x;
		logic [8:0] py;
		logic [3:0] fg;
		logic [3:0] bg;
		logic [7:0] bits;
		logic       untouched;
		logic       bg_clear;
	} item_t;

	// One finished pixel from a lane
	typedef struct packed {
		logic [9:0] x;
		logic       we;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pix_t;

	// Fixed 16-colour palette, packed as red, green, blue
	function automatic logic [23:0] palette_rgb(input logic [3:0] ci);
		logic [23:0] rgb;
		unique case (ci)
			4'd0:  rgb = {8'd0,   8'd0,   8'd0};
			4'd1:  rgb = {8'd0,   8'd0,   8'd170};
			4'd2:  rgb = {8'd0,   8'd170, 8'd0};
			4'd3:  rgb = {8'd0,   8'd170, 8'd170};
			4'd4:  rgb = {8'd170, 8'd0,   8'd0};
			4'd5:  rgb = {8'd170, 8'd0,   8'd170};
			4'd6:  rgb = {8'd170, 8'd85,  8'd0};
			4'd7:  rgb = {8'd170, 8'd170, 8'd170};
			4'd8:  rgb = {8'd85,  8'd85,  8'd85};
			4'd9:  rgb = {8'd85,  8'd85,  8'd255};
			4'd10: rgb = {8'd85,  8'd255, 8'd85};
			4'd11: rgb = {8'd85,  8'd255, 8'd255};
			4'd12: rgb = {8'd255, 8'd85,  8'd85};
			4'd13: rgb = {8'd255, 8'd85,  8'd255};
			4'd14: rgb = {8'd255, 8'd255, 8'd85};
			default: rgb = {8'd255, 8'd255, 8'd255};
		endcase
		return rgb;
	endfunction

endpackage

/* design/text_cell_glyph_rasterizer_unit.sv */
// Glyph line rasterizer: one glyph line item in, eight pixel items out.
// An accepted item is registered in the decode stage, even while the last
// line drains, and moves to the line buffer that presents its pixels once free.
// Throughput: one pixel per cycle while out_ready is high, through the
// single output port that drains the eight lane results of a line.
// Reset: arst_n clears the pipeline and loads the registers with their
// defaults (cursor off at 0,0, default attribute 0x07, transparent index 0).
module text_cell_glyph_rasterizer_unit
	import tcgr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [4:0]  cell_row,
	input  logic [6:0]  cell_column,
	input  logic [3:0]  glyph_line,
	input  logic [7:0]  char_code,
	input  logic [7:0]  attribute,
	input  logic [7:0]  glyph_bits,
	input  logic        blink_phase,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [9:0]  pixel_x,
	output logic [8:0]  pixel_y,
	output logic        write_enable,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic        last_pixel
);

	cfg_t                  cfg_q;
	logic                  valid_s1;
	logic                  take_s1;
	item_t                 item_s1;
	pix_t [CELL_WIDTH-1:0] lanes;

	// Configuration writes always complete
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cursor_enable          <= 1'b0;
			cfg_q.cursor_row             <= 5'd0;
			cfg_q.cursor_column          <= 7'd0;
			cfg_q.blank_attr             <= 8'h07;
			cfg_q.transparent_background <= 4'd0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_CURSOR_ENABLE: cfg_q.cursor_enable          <= cfg_data[0];
				CFG_CURSOR_ROW:    cfg_q.cursor_row             <= cfg_data[4:0];
				CFG_CURSOR_COLUMN: cfg_q.cursor_column          <= cfg_data[6:0];
				CFG_DEFAULT_ATTR:  cfg_q.blank_attr             <= cfg_data;
				CFG_TRANSP_BG:     cfg_q.transparent_background <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	tcgr_decode u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cell_row    (cell_row),
		.cell_column (cell_column),
		.glyph_line  (glyph_line),
		.char_code   (char_code),
		.attribute   (attribute),
		.glyph_bits  (glyph_bits),
		.blink_phase (blink_phase),
		.take_s1     (take_s1),
		.valid_s1    (valid_s1),
		.item_s1     (item_s1)
	);

	// One lane per glyph column
	for (genvar g = 0; g < CELL_WIDTH; g++) begin : g_lane
		tcgr_lane u_lane (
			.item     (item_s1),
			.lane_idx (LANE_W'(g)),
			.pix      (lanes[g])
		);
	end

	tcgr_serializer u_ser (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s1     (valid_s1),
		.py_s1        (item_s1.py),
		.lanes        (lanes),
		.take_s1      (take_s1),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.write_enable (write_enable),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.last_pixel   (last_pixel)
	);

endmodule

/* design/tcgr_decode.sv */
module tcgr_decode
	import tcgr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [4:0]  cell_row,
	input  logic [6:0]  cell_column,
	input  logic [3:0]  glyph_line,
	input  logic [7:0]  char_code,
	input  logic [7:0]  attribute,
	input  logic [7:0]  glyph_bits,
	input  logic        blink_phase,
	input  logic        take_s1,
	output logic        valid_s1,
	output item_t       item_s1
);

	logic  cursor_here;
	logic  [3:0] fg;
	logic  [3:0] bg;
	item_t item_d;

	// Work out the colours, the cursor swap and the line coordinates
	always_comb begin
		cursor_here = cfg.cursor_enable && blink_phase &&
			(cell_row == cfg.cursor_row) && (cell_column == cfg.cursor_column);
		fg = attribute[3:0] & NIBBLE_MASK;
		bg = attribute[7:4] & NIBBLE_MASK;
		item_d.fg        = cursor_here ? bg : fg;
		item_d.bg        = cursor_here ? fg : bg;
		item_d.untouched = (char_code == SPACE_CODE) &&
			(attribute == cfg.blank_attr) && !cursor_here;
		item_d.bg_clear  = (item_d.bg == cfg.transparent_background);
		item_d.bits      = glyph_bits;
		item_d.base_x    = 10'(32'(cell_column) * CELL_WIDTH);
		item_d.py        = 9'(32'(cell_row) * CELL_HEIGHT + 32'(glyph_line));
	end

	// Accept a new item whenever the stage is empty or being drained
	assign in_ready = !valid_s1 || take_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (take_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// Hold the decoded item
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= item_d;
		end
	end

endmodule

/* design/tcgr_lane.sv */
module tcgr_lane
	import tcgr_pkg::*;
(
	input  item_t             item,
	input  logic [LANE_W-1:0] lane_idx,
	output pix_t              pix
);

	logic        on;
	logic [3:0]  ci;
	logic [23:0] rgb;

	// Colour one glyph column
	always_comb begin
		on  = |(item.bits & (LEFT_BIT >> lane_idx));
		ci  = on ? item.fg : item.bg;
		rgb = palette_rgb(ci);
		pix.x  = item.base_x + 10'(lane_idx);
		pix.we = !item.untouched && (on || !item.bg_clear);
		pix.red   = pix.we ? rgb[23:16] : 8'd0;
		pix.green = pix.we ? rgb[15:8]  : 8'd0;
		pix.blue  = pix.we ? rgb[7:0]   : 8'd0;
	end

endmodule

/* design/tcgr_serializer.sv */
`include "assert_macros.svh"

module tcgr_serializer
	import tcgr_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   valid_s1,
	input  logic [8:0]             py_s1,
	input  pix_t [CELL_WIDTH-1:0]  lanes,
	output logic                   take_s1,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [9:0]             pixel_x,
	output logic [8:0]             pixel_y,
	output logic                   write_enable,
	output logic [7:0]             red,
	output logic [7:0]             green,
	output logic [7:0]             blue,
	output logic                   last_pixel
);

	localparam logic [LANE_W-1:0] LAST_IDX = LANE_W'(CELL_WIDTH - 1);

	pix_t [CELL_WIDTH-1:0] pix_s2;
	logic [8:0]            py_s2;
	logic                  valid_s2;
	logic [LANE_W-1:0]     idx_q;
	logic                  out_acc;
	logic                  at_last;

	assign at_last = (idx_q == LAST_IDX);
	assign out_acc = out_valid && out_ready;
	// Load the lane results once the previous line has fully drained
	assign take_s1 = valid_s1 && (!valid_s2 || (out_acc && at_last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q    <= '0;
		end else begin
			if (take_s1) begin
				valid_s2 <= 1'b1;
				idx_q    <= '0;
			end else if (out_acc) begin
				if (at_last) begin
					valid_s2 <= 1'b0;
					idx_q    <= '0;
				end else begin
					idx_q <= idx_q + LANE_W'(1);
				end
			end
		end
	end

	// Hold the whole line of pixels
	always_ff @(posedge clk) begin
		if (take_s1) begin
			pix_s2 <= lanes;
			py_s2  <= py_s1;
		end
	end

	// Present one pixel per cycle while out_ready is high, left to right
	assign out_valid    = valid_s2;
	assign pixel_x      = pix_s2[idx_q].x;
	assign pixel_y      = py_s2;
	assign write_enable = pix_s2[idx_q].we;
	assign red          = pix_s2[idx_q].red;
	assign green        = pix_s2[idx_q].green;
	assign blue         = pix_s2[idx_q].blue;
	assign last_pixel   = at_last;

	`TCGR_ASSERT_IMP(a_idx_idle, !valid_s2, idx_q == '0, "pixel index not at rest while empty")
	`TCGR_ASSERT_NXT(a_idx_step, out_acc && !at_last, idx_q == $past(idx_q) + LANE_W'(1), "pixel index did not advance")
	`TCGR_ASSERT_NXT(a_drain, out_acc && at_last && !valid_s1, !valid_s2, "line buffer not freed after last pixel")
	`TCGR_ASSERT_IMP(a_no_overwrite, take_s1 && valid_s2, out_acc && at_last, "line buffer overwritten before drained")

endmodule
